>>> rtl/multi_key_debounce_event_scanner_defines.svh
// Assertion macros shared by the key scanner RTL.
`ifndef MULTI_KEY_DEBOUNCE_EVENT_SCANNER_DEFINES_SVH
`define MULTI_KEY_DEBOUNCE_EVENT_SCANNER_DEFINES_SVH

// Checked only while the block is out of reset.
`define MKD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every edge, including during reset.
`define MKD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/mkd_pkg.sv
// Shared constants, codes and types of the key debounce scanner.
`timescale 1ns / 1ps
`default_nettype none
package mkd_pkg;

	localparam int KEY_SLOTS_MAX = 8;
	localparam int NUM_KEYS_DEF  = 8;
	localparam int KEY_W         = 3;
	localparam int KIND_W        = 3;
	localparam int MASK_W        = 8;
	localparam int TICK_W        = 32;
	localparam int TIME_W        = 16;
	localparam int MODE_W        = 4;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;

	localparam logic [MODE_W-1:0] MODE_RST     = 4'd7;
	localparam logic [TIME_W-1:0] DEBOUNCE_RST = 16'd5;
	localparam logic [TIME_W-1:0] LONG_RST     = 16'd500;
	localparam logic [TIME_W-1:0] REPEAT_RST   = 16'd100;

	// Bit positions in the mode register.
	localparam int MODE_UPDOWN = 0;
	localparam int MODE_CLICK  = 1;
	localparam int MODE_LONG   = 2;
	localparam int MODE_REPEAT = 3;

	typedef enum logic [KIND_W-1:0] {
		EV_DOWN   = 3'd0,
		EV_UP     = 3'd1,
		EV_CLICK  = 3'd2,
		EV_LONG   = 3'd3,
		EV_REPEAT = 3'd4
	} ev_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE     = 3'd0,
		REG_DEBOUNCE = 3'd1,
		REG_LONG     = 3'd2,
		REG_REPEAT   = 3'd3,
		REG_LONG_EN  = 3'd4,
		REG_ACT_HIGH = 3'd5,
		REG_KEY_EN   = 3'd6
	} cfg_reg_t;

	// Operands of the shared elapsed-time comparator.
	typedef struct packed {
		logic [TICK_W-1:0] base;
		logic [TIME_W-1:0] limit;
	} cmp_req_t;

endpackage
`default_nettype wire

>>> rtl/mkd_if.sv
// Valid/ready channel interfaces for scan items and event results.
`timescale 1ns / 1ps
`default_nettype none
interface mkd_scan_if
	import mkd_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [TICK_W-1:0] now_tick;
	logic [MASK_W-1:0] pin_levels;

	modport source(output valid, output now_tick, output pin_levels, input ready);
	modport sink(input valid, input now_tick, input pin_levels, output ready);
endinterface

interface mkd_event_if
	import mkd_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic              event_valid;
	logic [KEY_W-1:0]  event_key;
	logic [KIND_W-1:0] event_kind;
	logic [MASK_W-1:0] pressed_mask;
	logic [MASK_W-1:0] raw_keys;

	modport source(output valid, output event_valid, output event_key, output event_kind,
		output pressed_mask, output raw_keys, input ready);
	modport sink(input valid, input event_valid, input event_key, input event_kind,
		input pressed_mask, input raw_keys, output ready);
endinterface
`default_nettype wire

>>> rtl/multi_key_debounce_event_scanner.sv
// Top level of the multi-key debounce and event scanner.
// Each accepted scan samples the pins, then one shared time comparator visits each of the
// K = min(NUM_KEYS, 8) keys once for edges and once for long press/repeat; the first event
// found ends the scan early. A new scan is accepted only once the last one has finished,
// and a result still waiting in the output register holds the sequencer in its final state.
// Reset: arst_n clears all key state, the output register and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_key_debounce_event_scanner_defines.svh"
module multi_key_debounce_event_scanner
	import mkd_pkg::*;
#(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mkd_scan_if.sink              scan,
	mkd_event_if.source           evt,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Only the first eight keys have pins; further keys are never scanned.
	localparam int SLOTS = (NUM_KEYS > KEY_SLOTS_MAX) ? KEY_SLOTS_MAX : NUM_KEYS;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RAW,
		ST_EDGE,
		ST_LONG,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0] key_q;

	// Configuration registers.
	logic [MODE_W-1:0] mode_q;
	logic [TIME_W-1:0] deb_time_q;
	logic [TIME_W-1:0] long_time_q;
	logic [TIME_W-1:0] rep_int_q;
	logic [MASK_W-1:0] long_en_q;
	logic [MASK_W-1:0] act_high_q;
	logic [MASK_W-1:0] key_en_q;

	// Per-key state.
	logic [SLOTS-1:0]  raw_q;
	logic [SLOTS-1:0]  stable_q;
	logic [SLOTS-1:0]  long_rep_q;
	logic [TICK_W-1:0] deb_start_q [SLOTS];
	logic [TICK_W-1:0] press_start_q [SLOTS];
	logic [TICK_W-1:0] last_rep_q [SLOTS];

	// The scan being worked on.
	logic [TICK_W-1:0] now_q;
	logic [MASK_W-1:0] pins_q;

	// The event found so far in this scan.
	logic              ev_valid_q;
	logic [KEY_W-1:0]  ev_key_q;
	logic [KIND_W-1:0] ev_kind_q;

	// Output register, so a finished result can wait while the next scan runs.
	logic              out_valid_q;
	logic              out_ev_valid_q;
	logic [KEY_W-1:0]  out_key_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [MASK_W-1:0] out_pressed_q;
	logic [MASK_W-1:0] out_raw_q;

	logic [SLOTS-1:0] en_vec;
	logic [SLOTS-1:0] len_vec;
	logic [SLOTS-1:0] ah_vec;
	logic             last_key;
	logic             cur_en;
	logic             cur_raw;
	logic             cur_stable;
	logic             cur_long;
	logic             cur_len;
	logic [KEY_W-1:0] cur_key;
	logic             edge_hit;
	logic             held_key;
	logic             out_free;
	logic             out_load;
	logic             scan_acc;
	cmp_req_t         cmp_req;
	logic             elapsed;

	assign en_vec   = key_en_q[SLOTS-1:0];
	assign len_vec  = long_en_q[SLOTS-1:0];
	assign ah_vec   = act_high_q[SLOTS-1:0];
	assign last_key = (key_q == IDX_W'(SLOTS - 1));
	assign cur_key  = KEY_W'(key_q);

	assign cur_en     = en_vec[key_q];
	assign cur_raw    = raw_q[key_q];
	assign cur_stable = stable_q[key_q];
	assign cur_long   = long_rep_q[key_q];
	assign cur_len    = len_vec[key_q];

	// Operand selection for the shared comparator: debounce during the edge pass,
	// then either the long-press hold time or the repeat interval.
	always_comb begin
		if (state_q == ST_EDGE) begin
			cmp_req.base  = deb_start_q[key_q];
			cmp_req.limit = deb_time_q;
		end else if (!cur_long) begin
			cmp_req.base  = press_start_q[key_q];
			cmp_req.limit = long_time_q;
		end else begin
			cmp_req.base  = last_rep_q[key_q];
			cmp_req.limit = rep_int_q;
		end
	end

	mkd_time_cmp u_cmp (
		.now     (now_q),
		.req     (cmp_req),
		.elapsed (elapsed)
	);

	// A stable edge is due once the raw state differs and has held long enough.
	assign edge_hit = cur_en && (cur_raw != cur_stable) && elapsed;
	// Only held keys with long press enabled take part in the second pass.
	assign held_key = cur_en && cur_stable && cur_len;

	assign out_free = !out_valid_q || evt.ready;
	// The finished scan moves into the output register in this cycle.
	assign out_load = (state_q == ST_FINISH) && out_free;
	assign scan_acc = scan.valid && scan.ready;

	assign scan.ready       = (state_q == ST_IDLE);
	assign evt.valid        = out_valid_q;
	assign evt.event_valid  = out_ev_valid_q;
	assign evt.event_key    = out_key_q;
	assign evt.event_kind   = out_kind_q;
	assign evt.pressed_mask = out_pressed_q;
	assign evt.raw_keys     = out_raw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			key_q          <= '0;
			mode_q         <= MODE_RST;
			deb_time_q     <= DEBOUNCE_RST;
			long_time_q    <= LONG_RST;
			rep_int_q      <= REPEAT_RST;
			long_en_q      <= '0;
			act_high_q     <= '0;
			key_en_q       <= '0;
			raw_q          <= '0;
			stable_q       <= '0;
			long_rep_q     <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				deb_start_q[i]   <= '0;
				press_start_q[i] <= '0;
				last_rep_q[i]    <= '0;
			end
			now_q          <= '0;
			pins_q         <= '0;
			ev_valid_q     <= 1'b0;
			ev_key_q       <= '0;
			ev_kind_q      <= '0;
			out_valid_q    <= 1'b0;
			out_ev_valid_q <= 1'b0;
			out_key_q      <= '0;
			out_kind_q     <= '0;
			out_pressed_q  <= '0;
			out_raw_q      <= '0;
		end else begin
			// The register empties when its transaction is taken, unless the next
			// result is loaded in the same cycle.
			if (out_valid_q && evt.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (scan_acc) begin
						now_q      <= scan.now_tick;
						pins_q     <= scan.pin_levels;
						ev_valid_q <= 1'b0;
						ev_key_q   <= '0;
						ev_kind_q  <= '0;
						state_q    <= ST_RAW;
					end
				end
				ST_RAW: begin
					// Sample every enabled key; a change restarts its debounce timer.
					for (int i = 0; i < SLOTS; i++) begin
						if (en_vec[i] && (raw_q[i] != ~(pins_q[i] ^ ah_vec[i]))) begin
							raw_q[i]       <= ~(pins_q[i] ^ ah_vec[i]);
							deb_start_q[i] <= now_q;
						end
					end
					key_q   <= '0;
					state_q <= ST_EDGE;
				end
				ST_EDGE: begin
					if (edge_hit) begin
						stable_q[key_q] <= cur_raw;
						if (cur_raw) begin
							press_start_q[key_q] <= now_q;
							last_rep_q[key_q]    <= now_q;
							long_rep_q[key_q]    <= 1'b0;
							if (mode_q[MODE_UPDOWN]) begin
								ev_valid_q <= 1'b1;
								ev_key_q   <= cur_key;
								ev_kind_q  <= EV_DOWN;
							end
						end else if (mode_q[MODE_UPDOWN]) begin
							ev_valid_q <= 1'b1;
							ev_key_q   <= cur_key;
							ev_kind_q  <= EV_UP;
						end else begin
							// Release without up reports: click, if enabled, unless a long press was seen.
							if (mode_q[MODE_CLICK] && !cur_long) begin
								ev_valid_q <= 1'b1;
								ev_key_q   <= cur_key;
								ev_kind_q  <= EV_CLICK;
							end
							long_rep_q[key_q] <= 1'b0;
						end
					end
					// The first report ends the scan; later edges wait for a later scan.
					if (edge_hit && (cur_raw ? mode_q[MODE_UPDOWN]
						: (mode_q[MODE_UPDOWN] || (mode_q[MODE_CLICK] && !cur_long)))) begin
						state_q <= ST_FINISH;
					end else if (last_key) begin
						key_q   <= '0;
						state_q <= ST_LONG;
					end else begin
						key_q <= key_q + 1'b1;
					end
				end
				ST_LONG: begin
					if (held_key && !cur_long && elapsed) begin
						// The long press is recorded even when neither long nor repeat
						// is reported, which also suppresses the click on release of this press.
						long_rep_q[key_q] <= 1'b1;
						if (mode_q[MODE_LONG] || mode_q[MODE_REPEAT]) begin
							last_rep_q[key_q] <= now_q;
							ev_valid_q        <= 1'b1;
							ev_key_q          <= cur_key;
							ev_kind_q         <= EV_LONG;
						end
					end else if (held_key && cur_long && mode_q[MODE_REPEAT] && elapsed) begin
						last_rep_q[key_q] <= now_q;
						ev_valid_q        <= 1'b1;
						ev_key_q          <= cur_key;
						ev_kind_q         <= EV_REPEAT;
					end

					if (held_key && elapsed && (cur_long ? mode_q[MODE_REPEAT]
						: (mode_q[MODE_LONG] || mode_q[MODE_REPEAT]))) begin
						state_q <= ST_FINISH;
					end else if (last_key) begin
						state_q <= ST_FINISH;
					end else begin
						key_q <= key_q + 1'b1;
					end
				end
				ST_FINISH: begin
					// Hand the transaction to the output register once it is free.
					if (out_load) begin
						out_valid_q    <= 1'b1;
						out_ev_valid_q <= ev_valid_q;
						out_key_q      <= ev_key_q;
						out_kind_q     <= ev_kind_q;
						out_pressed_q  <= MASK_W'(stable_q);
						out_raw_q      <= MASK_W'(raw_q & en_vec);
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Register writes must arrive only while no scan is in flight; the block does not enforce this.
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MODE: begin
						mode_q <= cfg_data[MODE_W-1:0];
					end
					REG_DEBOUNCE: begin
						if (cfg_data != '0) begin
							deb_time_q <= cfg_data[TIME_W-1:0];
						end
					end
					REG_LONG: begin
						if (cfg_data != '0) begin
							long_time_q <= cfg_data[TIME_W-1:0];
						end
					end
					REG_REPEAT: begin
						if (cfg_data != '0) begin
							rep_int_q <= cfg_data[TIME_W-1:0];
						end
					end
					REG_LONG_EN: begin
						long_en_q <= cfg_data[MASK_W-1:0];
					end
					REG_ACT_HIGH: begin
						act_high_q <= cfg_data[MASK_W-1:0];
					end
					REG_KEY_EN: begin
						// A key whose enable bit flips in either direction starts from scratch.
						for (int i = 0; i < SLOTS; i++) begin
							if (key_en_q[i] != cfg_data[i]) begin
								raw_q[i]         <= 1'b0;
								stable_q[i]      <= 1'b0;
								long_rep_q[i]    <= 1'b0;
								deb_start_q[i]   <= '0;
								press_start_q[i] <= '0;
								last_rep_q[i]    <= '0;
							end
						end
						key_en_q <= cfg_data[MASK_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// The key counter never leaves the range of implemented keys while scanning.
	`MKD_ASSERT(a_key_in_range, (state_q == ST_EDGE || state_q == ST_LONG) |-> (key_q <= IDX_W'(SLOTS - 1)), "key counter out of range")
	// A result without an event carries zero key and kind.
	`MKD_ASSERT(a_no_event_zero, (evt.valid && !evt.event_valid) |-> (evt.event_key == '0 && evt.event_kind == '0), "idle result has nonzero key or kind")
	// Reported kinds stay within the defined codes.
	`MKD_ASSERT(a_kind_legal, (evt.valid && evt.event_valid) |-> (evt.event_kind <= EV_REPEAT), "undefined event kind")
	// Reset leaves no result pending.
	`MKD_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !evt.valid, "result valid right after reset")

endmodule
`default_nettype wire

>>> rtl/mkd_time_cmp.sv
// Shared modular elapsed-time comparator used for every timing check.
`timescale 1ns / 1ps
`default_nettype none
module mkd_time_cmp
	import mkd_pkg::*;
(
	input  logic [TICK_W-1:0] now,
	input  cmp_req_t          req,
	output logic              elapsed
);

	logic [TICK_W-1:0] diff;

	// The difference wraps modulo 2^32, so a tick counter rollover is harmless.
	assign diff    = now - req.base;
	assign elapsed = (diff >= {{(TICK_W - TIME_W){1'b0}}, req.limit});

endmodule
`default_nettype wire
